[rtl/krnk_pkg.sv]
// Shared types, constants and key classification for the keyboard report decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package krnk_pkg;

  localparam int NUM_FONTS    = 4;
  localparam int NUM_PALETTES = 4;
  localparam int SLOTS        = 6;
  localparam int SIDX_W       = $clog2(SLOTS);
  localparam int START_W      = $clog2(SLOTS + 1);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef logic [7:0] key_t;

  // Usage codes with a dedicated action.
  localparam key_t KEY_NONE       = 8'd0;
  localparam key_t KEY_CLEAR      = 8'd58;
  localparam key_t KEY_BACKSPACE  = 8'd42;
  localparam key_t KEY_DELETE     = 8'd76;
  localparam key_t KEY_UP         = 8'd82;
  localparam key_t KEY_DOWN       = 8'd81;
  localparam key_t KEY_LEFT       = 8'd80;
  localparam key_t KEY_RIGHT      = 8'd79;
  localparam key_t KEY_FONT       = 8'd61;
  localparam key_t KEY_PALETTE    = 8'd62;
  localparam key_t KEY_PRINT1_LO  = 8'd4;
  localparam key_t KEY_PRINT1_HI  = 8'd40;
  localparam key_t KEY_PRINT2_LO  = 8'd44;
  localparam key_t KEY_PRINT2_HI  = 8'd56;

  localparam logic [7:0] MOD_NONE  = 8'd0;
  localparam logic [7:0] MOD_SHIFT = 8'd2;

  typedef enum logic [3:0] {
    ACT_IGNORED   = 4'd0,
    ACT_PRINTABLE = 4'd1,
    ACT_CLEAR     = 4'd2,
    ACT_BACKSPACE = 4'd3,
    ACT_DELETE    = 4'd4,
    ACT_UP        = 4'd5,
    ACT_DOWN      = 4'd6,
    ACT_LEFT      = 4'd7,
    ACT_RIGHT     = 4'd8,
    ACT_FONT      = 4'd9,
    ACT_PALETTE   = 4'd10
  } action_t;

  typedef enum logic [1:0] {
    CASE_LOWER = 2'd0,
    CASE_SHIFT = 2'd1,
    CASE_OTHER = 2'd2
  } letter_case_t;

  // One classified report handed from the front end to the back end.
  typedef struct packed {
    logic [7:0]             modifier;
    key_t [SLOTS-1:0]       keys;
    logic [SLOTS-1:0]       emit;
    logic                   rep_last;
  } job_t;

  function automatic action_t classify(input key_t code);
    action_t act;
    unique case (code) inside
      [KEY_PRINT1_LO:KEY_PRINT1_HI],
      [KEY_PRINT2_LO:KEY_PRINT2_HI]: act = ACT_PRINTABLE;
      KEY_CLEAR:                     act = ACT_CLEAR;
      KEY_BACKSPACE:                 act = ACT_BACKSPACE;
      KEY_DELETE:                    act = ACT_DELETE;
      KEY_UP:                        act = ACT_UP;
      KEY_DOWN:                      act = ACT_DOWN;
      KEY_LEFT:                      act = ACT_LEFT;
      KEY_RIGHT:                     act = ACT_RIGHT;
      KEY_FONT:                      act = ACT_FONT;
      KEY_PALETTE:                   act = ACT_PALETTE;
      default:                       act = ACT_IGNORED;
    endcase
    return act;
  endfunction

  // Wrapping step of a selection index with num choices.
  function automatic logic [1:0] next_sel(input logic [1:0] sel, input int num);
    logic [1:0] res;
    if (int'(sel) >= num - 1) begin
      res = 2'd0;
    end else begin
      res = sel + 2'd1;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/krnk_front.sv]
// Front end: accepts reports, compares them with the previous report and
// classifies them into jobs for the queue. Depends on krnk_pkg.
`default_nettype none

module krnk_front import krnk_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       in_modifier,
  input  wire key_t [SLOTS-1:0] in_keys,
  input  wire logic             q_ready,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [7:0]       prev_mod_r;
  key_t [SLOTS-1:0] prev_keys_r;

  logic                 accept;
  logic                 equal;
  logic                 found;
  logic [START_W-1:0]   start;
  logic [SLOTS-1:0]     run_nz;
  logic [SLOTS-1:0]     prev_live;
  logic [SLOTS-1:0]     seen;
  logic [SLOTS-1:0]     emit;
  logic                 rep_last;

  always_comb begin
    // Prefix scan: stop at the first differing slot or at an empty slot.
    equal = 1'b1;
    found = 1'b0;
    start = START_W'(SLOTS);
    for (int k = 0; k < SLOTS; k++) begin
      if (!found) begin
        if (in_keys[k] != prev_keys_r[k]) begin
          equal = 1'b0;
          start = START_W'(k);
          found = 1'b1;
        end else if (in_keys[k] == KEY_NONE) begin
          start = START_W'(k);
          found = 1'b1;
        end
      end
    end

    run_nz[0]    = (in_keys[0] != KEY_NONE);
    prev_live[0] = (prev_keys_r[0] != KEY_NONE);
    for (int k = 1; k < SLOTS; k++) begin
      run_nz[k]    = run_nz[k-1] && (in_keys[k] != KEY_NONE);
      prev_live[k] = prev_live[k-1] && (prev_keys_r[k] != KEY_NONE);
    end

    for (int k = 0; k < SLOTS; k++) begin
      seen[k] = 1'b0;
      for (int j = 0; j < SLOTS; j++) begin
        if (prev_live[j] && (prev_keys_r[j] == in_keys[k])) begin
          seen[k] = 1'b1;
        end
      end
      emit[k] = run_nz[k] && (START_W'(k) >= start) && !seen[k];
    end

    rep_last = run_nz[0] && equal && (in_modifier == prev_mod_r);
  end

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign q_push   = accept && (rep_last || (|emit));

  assign q_job.modifier = in_modifier;
  assign q_job.keys     = in_keys;
  assign q_job.emit     = emit;
  assign q_job.rep_last = rep_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mod_r  <= '0;
      prev_keys_r <= '0;
    end else if (accept) begin
      prev_mod_r  <= in_modifier;
      prev_keys_r <= in_keys;
    end
  end

endmodule

`default_nettype wire

[rtl/krnk_queue.sv]
// Short job queue between the front end and the back end.
// Depends on krnk_pkg for the job type and depth.
`default_nettype none

module krnk_queue import krnk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      push_ready,
  input  wire logic pop,
  output logic      pop_valid,
  output job_t      pop_job
);

  job_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  logic do_push;
  logic do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] res;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + QPTR_W'(1);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= bump(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= bump(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[rtl/krnk_back.sv]
// Back end: walks a job's keys, one word per cycle unless stalled, and keeps the
// last handled key and the font and palette selections. Depends on krnk_pkg.
`default_nettype none

module krnk_back import krnk_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic [3:0] out_action,
  output logic [7:0] out_key_code,
  output logic [7:0] out_key_modifier,
  output logic [1:0] out_letter_case,
  output logic [1:0] out_font_index,
  output logic [1:0] out_palette_index,
  output logic       out_last
);

  logic         w_valid_r;
  job_t         w_job_r;
  logic [7:0]   last_mod_r;
  key_t         last_key_r;
  logic [1:0]   font_r;
  logic [1:0]   pal_r;

  logic         out_valid_r;
  action_t      out_action_r;
  key_t         out_key_r;
  logic [7:0]   out_mod_r;
  letter_case_t out_case_r;
  logic [1:0]   out_font_r;
  logic [1:0]   out_pal_r;
  logic         out_last_r;

  logic [SIDX_W-1:0] sel_idx;
  logic [SLOTS-1:0]  emit_nxt;
  logic [7:0]        cur_mod;
  key_t              cur_key;
  action_t           act;
  letter_case_t      lcase;
  logic [1:0]        font_nxt;
  logic [1:0]        pal_nxt;
  logic              fire;
  logic              done;

  always_comb begin
    sel_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (w_job_r.emit[k]) begin
        sel_idx = SIDX_W'(k);
      end
    end
    emit_nxt = w_job_r.emit & (w_job_r.emit - SLOTS'(1));

    cur_mod = w_job_r.rep_last ? last_mod_r : w_job_r.modifier;
    cur_key = w_job_r.rep_last ? last_key_r : w_job_r.keys[sel_idx];
    act     = classify(cur_key);

    if (act != ACT_PRINTABLE) begin
      lcase = CASE_LOWER;
    end else if (cur_mod == MOD_NONE) begin
      lcase = CASE_LOWER;
    end else if (cur_mod == MOD_SHIFT) begin
      lcase = CASE_SHIFT;
    end else begin
      lcase = CASE_OTHER;
    end

    font_nxt = (act == ACT_FONT)    ? next_sel(font_r, NUM_FONTS)   : font_r;
    pal_nxt  = (act == ACT_PALETTE) ? next_sel(pal_r, NUM_PALETTES) : pal_r;
  end

  assign fire  = w_valid_r && (!out_valid_r || out_ready);
  assign done  = fire && (w_job_r.rep_last || (emit_nxt == '0));
  assign q_pop = q_valid && (!w_valid_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      last_mod_r  <= '0;
      last_key_r  <= '0;
      font_r      <= '0;
      pal_r       <= '0;
    end else begin
      if (q_pop) begin
        w_valid_r <= 1'b1;
      end else if (done) begin
        w_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        last_mod_r  <= cur_mod;
        last_key_r  <= cur_key;
        font_r      <= font_nxt;
        pal_r       <= pal_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_job_r <= q_job;
    end else if (fire) begin
      w_job_r.emit <= emit_nxt;
    end
    if (fire) begin
      out_action_r <= act;
      out_key_r    <= cur_key;
      out_mod_r    <= cur_mod;
      out_case_r   <= lcase;
      out_font_r   <= font_nxt;
      out_pal_r    <= pal_nxt;
      out_last_r   <= w_job_r.rep_last || (emit_nxt == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_action        = out_action_r;
  assign out_key_code      = out_key_r;
  assign out_key_modifier  = out_mod_r;
  assign out_letter_case   = out_case_r;
  assign out_font_index    = out_font_r;
  assign out_palette_index = out_pal_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

[rtl/keyboard_report_new_key_decoder.sv]
// A report's job passes through the job queue and the back end's job register, and each of its
// result words through the output register. Throughput: one result word per cycle unless the
// output stalls; n new keys give n words (at most six), all on the back end's single result path.
// The front end takes a new report every cycle while the two-entry job queue has room.
// Reset (rst_n low, synchronous) clears the previous report, the last handled key and modifier,
// the font and palette selections, the queue and all valid flags. Depends on krnk_pkg.
`default_nettype none

module keyboard_report_new_key_decoder import krnk_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_modifier_bits,
  input  wire logic [7:0] in_key_slot_0,
  input  wire logic [7:0] in_key_slot_1,
  input  wire logic [7:0] in_key_slot_2,
  input  wire logic [7:0] in_key_slot_3,
  input  wire logic [7:0] in_key_slot_4,
  input  wire logic [7:0] in_key_slot_5,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_action,
  output logic [7:0]      out_key_code,
  output logic [7:0]      out_key_modifier,
  output logic [1:0]      out_letter_case,
  output logic [1:0]      out_font_index,
  output logic [1:0]      out_palette_index,
  output logic            out_last
);

  // The six key slots travel as one packed array inside the block.
  key_t [SLOTS-1:0] in_keys;

  assign in_keys[0] = in_key_slot_0;
  assign in_keys[1] = in_key_slot_1;
  assign in_keys[2] = in_key_slot_2;
  assign in_keys[3] = in_key_slot_3;
  assign in_keys[4] = in_key_slot_4;
  assign in_keys[5] = in_key_slot_5;

  logic fq_push;
  job_t fq_job;
  logic fq_ready;
  logic qb_valid;
  job_t qb_job;
  logic qb_pop;

  // The front end compares each report with the previous one and turns it into a job:
  // a mask of the slots whose keys are new, or a request to repeat the last handled key.
  // Reports that produce no result word are absorbed here and never reach the queue.
  krnk_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_modifier (in_modifier_bits),
    .in_keys     (in_keys),
    .q_ready     (fq_ready),
    .q_push      (fq_push),
    .q_job       (fq_job)
  );

  // The queue lets the front end keep taking reports while the back end is still
  // emitting the keys of an earlier one.
  krnk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fq_push),
    .push_job   (fq_job),
    .push_ready (fq_ready),
    .pop        (qb_pop),
    .pop_valid  (qb_valid),
    .pop_job    (qb_job)
  );

  // The back end walks the mask one key per cycle unless the output stalls, classifies the
  // key, steps the font and palette selections and loads the output register. The next job
  // is taken in the same cycle the last word of the current one is produced.
  krnk_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (qb_valid),
    .q_job             (qb_job),
    .q_pop             (qb_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_key_code      (out_key_code),
    .out_key_modifier  (out_key_modifier),
    .out_letter_case   (out_letter_case),
    .out_font_index    (out_font_index),
    .out_palette_index (out_palette_index),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

[rtl/krnk_checker.sv]
// Port-level assertions for keyboard_report_new_key_decoder and the bind that attaches them.
// Depends on krnk_pkg and on the top level's port names.
`default_nettype none

module krnk_checker import krnk_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_action,
  input wire logic [7:0] out_key_code,
  input wire logic [1:0] out_letter_case,
  input wire logic [1:0] out_font_index,
  input wire logic       out_last
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_key_code)
      && $stable(out_last))
    else $error("result word changed while stalled");

  // No result word right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Letter case is only given for printable keys.
  a_case_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != ACT_PRINTABLE) |-> out_letter_case == CASE_LOWER)
    else $error("letter case on non-printable action");

  // A printable action carries a printable usage code.
  a_printable_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_PRINTABLE) |->
      ((out_key_code >= KEY_PRINT1_LO) && (out_key_code <= KEY_PRINT1_HI)) ||
      ((out_key_code >= KEY_PRINT2_LO) && (out_key_code <= KEY_PRINT2_HI)))
    else $error("printable action with non-printable code");

  // Consecutive words that are not font steps keep the font selection.
  a_font_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready ##1 out_valid && (out_action != ACT_FONT)
      |-> out_font_index == $past(out_font_index))
    else $error("font selection changed without a font step");

endmodule

bind keyboard_report_new_key_decoder krnk_checker u_krnk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_action      (out_action),
  .out_key_code    (out_key_code),
  .out_letter_case (out_letter_case),
  .out_font_index  (out_font_index),
  .out_last        (out_last)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for keyboard_report_new_key_decoder: drives boot keyboard reports
// and checks every result word against a predictor of the new-key decoding rules.
// Depends on krnk_pkg and the keyboard_report_new_key_decoder RTL only.

module tb_top;
  import krnk_pkg::*;

  // Share of cycles in which each side idles while random idling is enabled.
  localparam int IDLE_PERCENT    = 36;
  // Length of the long receiver hold-off that fills the decoder's job queue.
  localparam int HOLD_OFF_CYCLES = 80;
  // Quiet cycles after the last expected word.
  localparam int TAIL_CYCLES     = 16;
  localparam int MAX_PRINTED     = 40;

  typedef key_t [SLOTS-1:0] report_keys_t;

  // One result word as the decoder should present it.
  typedef struct {
    action_t      action;
    key_t         key_code;
    logic [7:0]   key_modifier;
    letter_case_t letter_case;
    logic [1:0]   font_index;
    logic [1:0]   palette_index;
    logic         last;
  } key_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_modifier_bits = 8'd0;
  logic [7:0] in_key_slot_0 = 8'd0;
  logic [7:0] in_key_slot_1 = 8'd0;
  logic [7:0] in_key_slot_2 = 8'd0;
  logic [7:0] in_key_slot_3 = 8'd0;
  logic [7:0] in_key_slot_4 = 8'd0;
  logic [7:0] in_key_slot_5 = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_action;
  logic [7:0] out_key_code;
  logic [7:0] out_key_modifier;
  logic [1:0] out_letter_case;
  logic [1:0] out_font_index;
  logic [1:0] out_palette_index;
  logic       out_last;

  // When set, neither side idles at random; the hold-off still applies.
  logic steady = 1'b0;
  // Bumped by a test to ask the receiver process for one long hold-off.
  int   hold_requests = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   mismatches = 0;

  // Words the decoder still owes, oldest first.
  key_word_t due_words[$];

  // Predictor state: mirrors what the decoder remembers between reports.
  logic [7:0]   prior_modifier = 8'd0;
  report_keys_t prior_keys = '0;
  logic [7:0]   handled_modifier = 8'd0;
  key_t         handled_key = 8'd0;
  logic [1:0]   font_sel = 2'd0;
  logic [1:0]   palette_sel = 2'd0;

  keyboard_report_new_key_decoder uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_modifier_bits  (in_modifier_bits),
    .in_key_slot_0     (in_key_slot_0),
    .in_key_slot_1     (in_key_slot_1),
    .in_key_slot_2     (in_key_slot_2),
    .in_key_slot_3     (in_key_slot_3),
    .in_key_slot_4     (in_key_slot_4),
    .in_key_slot_5     (in_key_slot_5),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_action        (out_action),
    .out_key_code      (out_key_code),
    .out_key_modifier  (out_key_modifier),
    .out_letter_case   (out_letter_case),
    .out_font_index    (out_font_index),
    .out_palette_index (out_palette_index),
    .out_last          (out_last)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  // A key counts as already held if it shows up in the prior report before its first empty slot.
  function automatic logic was_held(input key_t code);
    logic found;
    logic ended;
    found = 1'b0;
    ended = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (prior_keys[j] == KEY_NONE) begin
        ended = 1'b1;
      end
      if (!ended && prior_keys[j] == code) begin
        found = 1'b1;
      end
    end
    return found;
  endfunction

  // Works out the word for one handled key, moves the font and palette selections on when
  // the key asks for it, and queues the word. The key becomes the last handled one whatever
  // its class, ignored keys included.
  task automatic handle_key(input logic [7:0] modifier, input key_t code);
    key_word_t w;
    w.action = ACT_IGNORED;
    w.letter_case = CASE_LOWER;
    handled_modifier = modifier;
    handled_key = code;
    if ((code >= KEY_PRINT1_LO && code <= KEY_PRINT1_HI) ||
        (code >= KEY_PRINT2_LO && code <= KEY_PRINT2_HI)) begin
      w.action = ACT_PRINTABLE;
      if (modifier == MOD_NONE) begin
        w.letter_case = CASE_LOWER;
      end else if (modifier == MOD_SHIFT) begin
        w.letter_case = CASE_SHIFT;
      end else begin
        w.letter_case = CASE_OTHER;
      end
    end else begin
      case (code)
        KEY_CLEAR:     w.action = ACT_CLEAR;
        KEY_BACKSPACE: w.action = ACT_BACKSPACE;
        KEY_DELETE:    w.action = ACT_DELETE;
        KEY_UP:        w.action = ACT_UP;
        KEY_DOWN:      w.action = ACT_DOWN;
        KEY_LEFT:      w.action = ACT_LEFT;
        KEY_RIGHT:     w.action = ACT_RIGHT;
        KEY_FONT: begin
          w.action = ACT_FONT;
          font_sel = (int'(font_sel) >= NUM_FONTS - 1) ? 2'd0 : font_sel + 2'd1;
        end
        KEY_PALETTE: begin
          w.action = ACT_PALETTE;
          palette_sel = (int'(palette_sel) >= NUM_PALETTES - 1) ? 2'd0 : palette_sel + 2'd1;
        end
        default: w.action = ACT_IGNORED;
      endcase
    end
    w.key_code = code;
    w.key_modifier = modifier;
    w.font_index = font_sel;
    w.palette_index = palette_sel;
    w.last = 1'b0;
    due_words.push_back(w);
  endtask

  // Decodes one accepted report into the words it must produce.
  task automatic decode_report(input logic [7:0] modifier, input report_keys_t keys);
    int  scan;
    int  produced;
    logic same;
    logic stop;
    produced = 0;
    if (keys[0] != KEY_NONE) begin
      // Walk the common prefix with the prior report. The walk ends at the first slot that
      // differs or at an empty slot that matches; slots past that point play no part.
      same = 1'b1;
      stop = 1'b0;
      scan = 0;
      while (scan < SLOTS && !stop) begin
        if (keys[scan] != prior_keys[scan]) begin
          same = 1'b0;
          stop = 1'b1;
        end else if (keys[scan] == KEY_NONE) begin
          stop = 1'b1;
        end else begin
          scan++;
        end
      end
      if (same && modifier == prior_modifier) begin
        // Held report: the last handled key is issued once more, with its own modifier.
        handle_key(handled_modifier, handled_key);
        produced = 1;
      end else begin
        // Keys from the first difference up to the next empty slot that the prior report
        // did not hold are new presses. A prefix match with a new modifier yields nothing.
        stop = 1'b0;
        while (scan < SLOTS && !stop) begin
          if (keys[scan] == KEY_NONE) begin
            stop = 1'b1;
          end else begin
            if (!was_held(keys[scan])) begin
              handle_key(modifier, keys[scan]);
              produced++;
            end
            scan++;
          end
        end
      end
    end
    if (produced > 0) begin
      due_words[$].last = 1'b1;
    end
    // Every report, the empty one too, becomes the prior one, slots past a zero included.
    prior_modifier = modifier;
    prior_keys = keys;
  endtask

  // ---------------------------------------------------------------------------------------
  // Driving and checking
  // ---------------------------------------------------------------------------------------

  function automatic report_keys_t slots6(input key_t k0, input key_t k1, input key_t k2,
                                          input key_t k3, input key_t k4, input key_t k5);
    return {k5, k4, k3, k2, k1, k0};
  endfunction

  // Offers one report from a falling edge, after an optional random gap, and holds it until
  // the decoder takes the report. The prediction is made at the accepting edge.
  task automatic send_report(input logic [7:0] modifier, input report_keys_t keys);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_modifier_bits = modifier;
    in_key_slot_0 = keys[0];
    in_key_slot_1 = keys[1];
    in_key_slot_2 = keys[2];
    in_key_slot_3 = keys[3];
    in_key_slot_4 = keys[4];
    in_key_slot_5 = keys[5];
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    decode_report(modifier, keys);
  endtask

  // The sender stops offering until every word owed so far has come out.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, field, got, want);
    end
  endtask

  // Receiver: random stalls, a steady stretch on request, and one long hold-off that
  // this process times itself once a test asks for it.
  always @(negedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else if (steady) begin
      out_ready = 1'b1;
    end else begin
      out_ready = ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Each word taken from the decoder is compared with the oldest owed word.
  always @(posedge clk) begin
    key_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word, key_code", int'(out_key_code), -1);
      end else begin
        want = due_words.pop_front();
        if (out_action !== want.action)
          report_mismatch("action", int'(out_action), int'(want.action));
        if (out_key_code !== want.key_code)
          report_mismatch("key_code", int'(out_key_code), int'(want.key_code));
        if (out_key_modifier !== want.key_modifier)
          report_mismatch("key_modifier", int'(out_key_modifier), int'(want.key_modifier));
        if (out_letter_case !== want.letter_case)
          report_mismatch("letter_case", int'(out_letter_case), int'(want.letter_case));
        if (out_font_index !== want.font_index)
          report_mismatch("font_index", int'(out_font_index), int'(want.font_index));
        if (out_palette_index !== want.palette_index)
          report_mismatch("palette_index", int'(out_palette_index), int'(want.palette_index));
        if (out_last !== want.last)
          report_mismatch("last", int'(out_last), int'(want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------

  // Key codes weighted toward the ones with an action, with the ignored ones and the
  // full byte range still well represented. Never returns the empty code.
  function automatic key_t random_key();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) begin
      return ($urandom_range(1) != 0) ? key_t'($urandom_range(KEY_PRINT1_HI, KEY_PRINT1_LO))
                                      : key_t'($urandom_range(KEY_PRINT2_HI, KEY_PRINT2_LO));
    end else if (pick < 72) begin
      case ($urandom_range(9))
        0: return KEY_CLEAR;
        1: return KEY_BACKSPACE;
        2: return KEY_DELETE;
        3: return KEY_UP;
        4: return KEY_DOWN;
        5: return KEY_LEFT;
        6: return KEY_RIGHT;
        7: return KEY_FONT;
        8: return KEY_PALETTE;
        default: return KEY_PALETTE;
      endcase
    end else if (pick < 86) begin
      case ($urandom_range(4))
        0: return key_t'($urandom_range(3, 1));
        1: return key_t'(41);
        2: return key_t'(43);
        3: return key_t'(57);
        default: return key_t'($urandom_range(255, 83));
      endcase
    end
    return key_t'($urandom_range(255, 1));
  endfunction

  function automatic logic [7:0] random_modifier();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      return MOD_NONE;
    end else if (pick < 65) begin
      return MOD_SHIFT;
    end
    return 8'($urandom_range(255));
  endfunction

  // Held reports, a held report after a modifier change, reordered keys that were all held
  // before, and a lone new key beside a held one.
  task automatic test_prefix_and_repeat();
    send_report(MOD_NONE, '0);
    send_report(8'hFF, slots6(KEY_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(MOD_NONE, slots6(8'd4, 0, 0, 0, 0, 0));
    send_report(MOD_NONE, slots6(8'd4, 0, 0, 0, 0, 0));
    send_report(MOD_SHIFT, slots6(8'd4, 0, 0, 0, 0, 0));
    send_report(MOD_SHIFT, slots6(8'd4, 8'd29, 0, 0, 0, 0));
    send_report(8'h81, slots6(8'd29, 8'd4, 0, 0, 0, 0));
    send_report(8'h81, slots6(8'd29, 8'd4, 0, 0, 0, 0));
  endtask

  // Every action class but the printable one, the font and palette selections wrapping,
  // keys repeated inside one report, and the ignored codes at both ends of the byte.
  task automatic test_action_classes();
    send_report(MOD_NONE, slots6(KEY_CLEAR, KEY_BACKSPACE, KEY_DELETE, KEY_UP, KEY_DOWN,
                                 KEY_LEFT));
    send_report(8'h40, slots6(KEY_RIGHT, KEY_FONT, KEY_PALETTE, KEY_FONT, KEY_PALETTE,
                              KEY_FONT));
    send_report(MOD_NONE, '0);
    send_report(MOD_NONE, slots6(KEY_PALETTE, KEY_FONT, 8'hFF, 8'd1, 8'd41, 8'd57));
    send_report(MOD_NONE, '0);
    send_report(8'h10, slots6(KEY_PALETTE, 0, 0, 0, 0, 0));
    send_report(MOD_NONE, slots6(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_report(8'h80, slots6(8'd3, 0, 0, 0, 0, 0));
  endtask

  // Slots after the first empty one are ignored; a full report held twice repeats its
  // last key; releasing every key gives nothing.
  task automatic test_scan_stops_at_empty_slot();
    send_report(8'hFF, slots6(8'd56, 8'd44, 8'd40, 8'd43, KEY_NONE, 8'hFF));
    send_report(8'hFF, slots6(8'd56, 8'd44, 8'd40, 8'd43, KEY_NONE, 8'h11));
    send_report(MOD_NONE, slots6(8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10));
    send_report(MOD_NONE, slots6(8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10));
    send_report(8'h80, '0);
  endtask

  // The receiver holds off for a long stretch while full reports of all-new keys keep
  // coming, so the job queue fills and the decoder refuses further reports for a while.
  task automatic test_backpressure(input int n);
    report_keys_t keys;
    steady = 1'b1;
    hold_requests++;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < SLOTS; i++) begin
        // Alternate between two disjoint code ranges so each report is all new presses.
        keys[i] = (k % 2 == 0) ? key_t'($urandom_range(20, 4)) : key_t'($urandom_range(40, 21));
      end
      send_report(random_modifier(), keys);
    end
    steady = 1'b0;
  endtask

  // Typing sessions: keys are pressed and released one at a time, held, reordered and
  // all let go, with the modifier changing now and then. A few reports are pure noise
  // over the whole byte range, empty first slots and stray codes after a zero among them.
  task automatic test_random_typing(input int n);
    key_t         held[$];
    logic [7:0]   modifier;
    report_keys_t keys;
    int           pick;
    modifier = MOD_NONE;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        if (held.size() < SLOTS) held.push_back(random_key());
      end else if (pick < 55) begin
        if (held.size() > 0) held.delete($urandom_range(held.size() - 1));
      end else if (pick >= 70 && pick < 80) begin
        modifier = random_modifier();
      end else if (pick >= 80 && pick < 87) begin
        held.delete();
      end else if (pick >= 87 && pick < 93) begin
        if (held.size() > 1) held.push_back(held.pop_front());
      end
      keys = '0;
      if (pick >= 93) begin
        for (int i = 0; i < SLOTS; i++) begin
          keys[i] = key_t'($urandom_range(255));
        end
        if ($urandom_range(3) == 0) keys[0] = KEY_NONE;
        if ($urandom_range(3) == 0) keys[$urandom_range(SLOTS - 2, 1)] = KEY_NONE;
        send_report(8'($urandom_range(255)), keys);
      end else begin
        for (int i = 0; i < held.size(); i++) begin
          keys[i] = held[i];
        end
        // Now and then a stray code sits beyond the first empty slot.
        if (held.size() < SLOTS - 1 && $urandom_range(9) == 0) begin
          keys[SLOTS - 1] = key_t'($urandom_range(255, 1));
        end
        send_report(modifier, keys);
      end
    end
  endtask

  task automatic test_steady_stream(input int n);
    steady = 1'b1;
    test_random_typing(n);
    steady = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_prefix_and_repeat();
    test_action_classes();
    test_scan_stops_at_empty_slot();
    drain_results();
    test_backpressure(14);
    drain_results();
    test_random_typing(125);
    test_steady_stream(20);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** keyboard_report_new_key_decoder: PASSED **");
    end else begin
      $display("** keyboard_report_new_key_decoder: FAILED **");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this, even with every report at six words.
  initial begin
    #2000000;
    $display("** keyboard_report_new_key_decoder: FAILED **");
    $finish;
  end

endmodule
